/* hdl/pcm_nearest_resampler_macros.svh */
// Assertion helpers for the resampler
`ifndef PCM_NEAREST_RESAMPLER_MACROS_SVH
`define PCM_NEAREST_RESAMPLER_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define PNR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that must also hold during reset
`define PNR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/pnr_pkg.sv */
package pnr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned STEP_W        = 16;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned MAX_COPIES    = 16;
  localparam int unsigned CNT_W         = $clog2(MAX_COPIES + 1);
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  // Unsigned 8-bit samples are re-centered by flipping the top bit
  localparam logic [BYTE_W-1:0] U8_BIAS = 8'h80;

  // Register reset values
  localparam logic              FORMAT_RST = 1'b1;
  localparam logic              STEREO_RST = 1'b1;
  localparam logic [STEP_W-1:0] STEP_RST   = 16'd256;
  localparam logic [POS_W-1:0]  TOTAL_RST  = '0;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_STEREO = 2'd1,
    CFG_STEP   = 2'd2,
    CFG_TOTAL  = 2'd3
  } cfg_idx_e;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

  // One converted frame as queued between front and back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic   not_empty;
    frame_t head;
  } queue_stat_t;

  // Raw sample bits to 16-bit signed PCM
  function automatic logic signed [SAMPLE_W-1:0] conv_sample(
    input logic [SAMPLE_W-1:0] raw,
    input logic                fmt16
  );
    logic [BYTE_W-1:0] b;
    b = raw[BYTE_W-1:0] ^ U8_BIAS;
    if (fmt16) begin
      return raw;
    end
    return {b, {(SAMPLE_W - BYTE_W){1'b0}}};
  endfunction

endpackage

/* hdl/pnr_front.sv */
module pnr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [pnr_pkg::SAMPLE_W-1:0] left_raw_i,
  input  logic [pnr_pkg::SAMPLE_W-1:0] right_raw_i,
  input  logic                  fmt16_i,
  input  logic                  stereo_i,
  input  logic                  pop_i,
  output pnr_pkg::queue_stat_t  stat_o
);

  pnr_pkg::frame_t                    mem_q [pnr_pkg::FIFO_DEPTH];
  pnr_pkg::frame_t                    wr_data;
  logic [pnr_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [pnr_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [pnr_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               push, pop;

  // Convert on entry so the queue holds signed PCM
  always_comb begin
    wr_data.left  = pnr_pkg::conv_sample(left_raw_i, fmt16_i);
    wr_data.right = stereo_i ? pnr_pkg::conv_sample(right_raw_i, fmt16_i)
                             : '0;
  end

  assign in_ready_o = (cnt_q != pnr_pkg::FIFO_CNT_W'(pnr_pkg::FIFO_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data;
    end
  end

  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.head      = mem_q[rd_ptr_q];

endmodule

/* hdl/pnr_back.sv */
module pnr_back #(
  parameter int unsigned FRAC_BITS = pnr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pnr_pkg::queue_stat_t             stat_i,
  output logic                             pop_o,
  input  logic [pnr_pkg::STEP_W-1:0]       step_i,
  input  logic [pnr_pkg::POS_W-1:0]        total_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [pnr_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [pnr_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                             run_last_o,
  output logic                             stream_done_o
);

  localparam int unsigned IDX_W = pnr_pkg::POS_W - FRAC_BITS;
  localparam logic [pnr_pkg::CNT_W-1:0] MAX_N = pnr_pkg::CNT_W'(pnr_pkg::MAX_COPIES);

  pnr_pkg::bk_state_e              state_q, state_d;
  pnr_pkg::frame_t                 frm_q, frm_d;
  logic [pnr_pkg::CNT_W-1:0]       n_q, n_d;
  logic [pnr_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [pnr_pkg::POS_W-1:0]       frame_q, frame_d;
  logic [pnr_pkg::POS_W-1:0]       emit_q, emit_d;
  logic                            out_valid_q, out_valid_d;
  pnr_pkg::frame_t                 out_frm_q, out_frm_d;
  logic                            run_last_q, run_last_d;
  logic                            done_q, done_d;

  logic [IDX_W-1:0]                target;
  logic [pnr_pkg::POS_W-1:0]       pos_next;
  logic [pnr_pkg::POS_W-1:0]       emit_next;
  logic [pnr_pkg::CNT_W-1:0]       n_next;
  logic                            cond, more, out_free, emit;

  // Copy test for this slot and a look-ahead for the next one
  always_comb begin
    target    = frame_q[IDX_W-1:0];
    pos_next  = pos_q + pnr_pkg::POS_W'(step_i);
    emit_next = emit_q + 1'b1;
    n_next    = n_q + 1'b1;
    cond      = (n_q < MAX_N) && (emit_q != total_i) &&
                (pos_q[pnr_pkg::POS_W-1:FRAC_BITS] == target);
    more      = (n_next < MAX_N) && (emit_next != total_i) &&
                (pos_next[pnr_pkg::POS_W-1:FRAC_BITS] == target);
    out_free  = !out_valid_q || out_ready_i;
  end

  // Sequencer: load a frame, emit its copies, advance the frame index
  always_comb begin
    state_d = state_q;
    frm_d   = frm_q;
    n_d     = n_q;
    pos_d   = pos_q;
    frame_d = frame_q;
    emit_d  = emit_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      pnr_pkg::BK_IDLE: begin
        if (stat_i.not_empty) begin
          pop_o   = 1'b1;
          frm_d   = stat_i.head;
          n_d     = '0;
          state_d = pnr_pkg::BK_RUN;
        end
      end
      pnr_pkg::BK_RUN: begin
        if (cond) begin
          if (out_free) begin
            emit   = 1'b1;
            n_d    = n_next;
            pos_d  = pos_next;
            emit_d = emit_next;
          end
        end else begin
          frame_d = frame_q + 1'b1;
          state_d = pnr_pkg::BK_IDLE;
        end
      end
      default: state_d = pnr_pkg::BK_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_frm_d  = out_frm_q;
    run_last_d = run_last_q;
    done_d     = done_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_frm_d   = frm_q;
      run_last_d  = !more;
      done_d      = (emit_next == total_i);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnr_pkg::BK_IDLE;
      n_q         <= '0;
      pos_q       <= '0;
      frame_q     <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      frame_q     <= frame_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    frm_q      <= frm_d;
    out_frm_q  <= out_frm_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = out_frm_q.left;
  assign right_out_o   = out_frm_q.right;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;

endmodule

/* hdl/pcm_nearest_resampler.sv */
// Nearest-neighbor PCM sample rate converter.
// Input channel (in_valid_i/in_ready_o) takes one frame of raw left/right
// sample bits per transaction. Output channel (out_valid_o/out_ready_i)
// delivers zero, one or up to 16 copies of each frame as signed 16-bit PCM,
// with run_last_o on the last copy of a frame and stream_done_o on the
// output that reaches the configured output total.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i),
// to be used only while no frame is in flight.
// The front end converts each frame and parks it in a two-entry queue; the
// back end runs one frame at a time: a load step, then one copy per cycle
// while the output register is free or being read, then a closing step that
// advances the frame index.
// The first output of a frame passes through the queue entry, the frame
// register and the output register.
// Reset clears the position, frame index and output count and restores the
// register defaults (16-bit, stereo, unity step, total zero).
// A stalled receiver holds the output register; the back end then waits,
// and once the queue fills in_ready_o drops.
module pcm_nearest_resampler #(
  parameter int unsigned FRAC_BITS = pnr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [pnr_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pnr_pkg::SAMPLE_W-1:0]        left_raw_i,
  input  logic [pnr_pkg::SAMPLE_W-1:0]        right_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pnr_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [pnr_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                                run_last_o,
  output logic                                stream_done_o
);

  logic                          fmt_q;
  logic                          stereo_q;
  logic [pnr_pkg::STEP_W-1:0]    step_q;
  logic [pnr_pkg::POS_W-1:0]     total_q;
  pnr_pkg::queue_stat_t          q_stat;
  logic                          pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= pnr_pkg::FORMAT_RST;
      stereo_q <= pnr_pkg::STEREO_RST;
      step_q   <= pnr_pkg::STEP_RST;
      total_q  <= pnr_pkg::TOTAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pnr_pkg::CFG_FORMAT: fmt_q    <= cfg_wdata_i[0];
        pnr_pkg::CFG_STEREO: stereo_q <= cfg_wdata_i[0];
        pnr_pkg::CFG_STEP:   step_q   <= cfg_wdata_i[pnr_pkg::STEP_W-1:0];
        pnr_pkg::CFG_TOTAL:  total_q  <= cfg_wdata_i[pnr_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  pnr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_raw_i  (left_raw_i),
    .right_raw_i (right_raw_i),
    .fmt16_i     (fmt_q),
    .stereo_i    (stereo_q),
    .pop_i       (pop),
    .stat_o      (q_stat)
  );

  pnr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (q_stat),
    .pop_o         (pop),
    .step_i        (step_q),
    .total_i       (total_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

  // Checks
`include "pcm_nearest_resampler_macros.svh"

  `PNR_ASSERT_RST(a_done_ends_run, out_valid_o && stream_done_o |-> run_last_o, "final output not marked as last copy")
  `PNR_ASSERT_ALWAYS(a_pop_nonempty, pop |-> q_stat.not_empty, "back end popped an empty queue")

endmodule
